// ===== hdl/cue_pkg.sv =====
// Shared types and constants for the stylesheet URL span extractor.
// Holds the scan phase and terminator enums, the result record and character codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cue_pkg;

  // Default width of byte offsets inside the scanner
  localparam int OFFSET_BITS_DEF = 16;

  // Width of the offset and length fields on the result channel
  localparam int RES_W = 16;

  // Result queue between scanner and output stage
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_U      = 8'h75;  // 'u'
  localparam logic [7:0] CH_R      = 8'h72;  // 'r'
  localparam logic [7:0] CH_L      = 8'h6C;  // 'l'
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
  localparam logic [7:0] CH_DQUOTE = 8'h22;  // '"'
  localparam logic [7:0] CH_SQUOTE = 8'h27;  // '\''
  localparam logic [7:0] CH_SEMI   = 8'h3B;  // ';'
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;  // first of the control whitespace run
  localparam logic [7:0] CH_CR     = 8'h0D;  // last of the control whitespace run

  typedef enum logic [1:0] {
    PH_SEEK,
    PH_AFTER_KW,
    PH_AFTER_PAREN,
    PH_SPAN
  } phase_t;

  typedef enum logic [2:0] {
    TK_NONE,
    TK_PAREN,
    TK_DQ_PAREN,
    TK_SQ_PAREN,
    TK_DQ,
    TK_SQ,
    TK_SEMI
  } term_kind_t;

  // One result record as it travels from scanner to output stage
  typedef struct packed {
    logic             found;
    logic [RES_W-1:0] start;
    logic [RES_W-1:0] length;
    logic             done;
  } res_t;

  // Push request from scanner into the queue
  typedef struct packed {
    logic push;
    res_t res;
  } push_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cue_scan.sv =====
// Front end: accepts stylesheet bytes, tracks keyword and span state, forms results.
// Depends on cue_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cue_scan #(
  parameter int OFFSET_BITS = cue_pkg::OFFSET_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_data,
  input  wire logic          in_last,
  output logic               in_ready,
  input  wire logic          q_full,
  output cue_pkg::push_t     push_o
);
  import cue_pkg::*;

  phase_t                 phase_r,  phase_nxt;
  logic [1:0]             prog_r,   prog_nxt;
  term_kind_t             kind_r,   kind_nxt;
  logic                   qp_r,     qp_nxt;
  logic [OFFSET_BITS-1:0] pp_r,     pp_nxt;
  logic [OFFSET_BITS-1:0] start_r,  start_nxt;
  logic [OFFSET_BITS-1:0] pos_r,    pos_nxt;

  logic                   acc;
  logic                   ws;
  logic                   open_semi;
  logic                   open_paren;
  logic                   examine;
  term_kind_t             kind_eff;
  logic [OFFSET_BITS-1:0] start_eff;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic                   hit;
  logic [OFFSET_BITS-1:0] len;
  logic [7:0]             kw_byte;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign ws       = is_ws(in_data);
  assign pos_inc  = pos_r + OFFSET_BITS'(1);

  // Decode which kind of span the current byte is checked against
  always_comb begin
    open_semi  = (phase_r == PH_AFTER_KW) && !ws && (in_data != CH_LPAREN) &&
                 (in_data != CH_DQUOTE) && (in_data != CH_SQUOTE);
    open_paren = (phase_r == PH_AFTER_PAREN) && !ws &&
                 (in_data != CH_DQUOTE) && (in_data != CH_SQUOTE);
    examine    = (phase_r == PH_SPAN) || open_semi || open_paren;
    kind_eff   = kind_r;
    start_eff  = start_r;
    if (open_semi) begin
      kind_eff  = TK_SEMI;
      start_eff = pos_r;
    end else if (open_paren) begin
      kind_eff  = TK_PAREN;
      start_eff = pos_r;
    end
  end

  // Expected next keyword byte
  always_comb begin
    case (prog_r)
      2'd0:    kw_byte = CH_U;
      2'd1:    kw_byte = CH_R;
      2'd2:    kw_byte = CH_L;
      default: kw_byte = CH_U;
    endcase
  end

  // Outputs: terminator detection and result record
  always_comb begin
    hit = 1'b0;
    len = pos_r - start_eff;
    if (examine) begin
      case (kind_eff)
        TK_PAREN:    hit = (in_data == CH_RPAREN);
        TK_DQ_PAREN,
        TK_SQ_PAREN: begin
          hit = qp_r && (in_data == CH_RPAREN);
          len = pp_r - start_eff;
        end
        TK_DQ:       hit = (in_data == CH_DQUOTE);
        TK_SQ:       hit = (in_data == CH_SQUOTE);
        TK_SEMI:     hit = (in_data == CH_SEMI);
        default:     hit = 1'b0;
      endcase
    end
    push_o.push       = acc && (hit || in_last);
    push_o.res.found  = hit;
    push_o.res.start  = hit ? RES_W'(start_eff) : '0;
    push_o.res.length = hit ? RES_W'(len) : '0;
    push_o.res.done   = in_last;
  end

  // Next state of the scanner
  always_comb begin
    phase_nxt = phase_r;
    prog_nxt  = prog_r;
    kind_nxt  = kind_r;
    qp_nxt    = qp_r;
    pp_nxt    = pp_r;
    start_nxt = start_r;
    pos_nxt   = pos_r;
    if (acc) begin
      case (phase_r)
        PH_SEEK: begin
          if ((prog_r != 2'd3) && (in_data == kw_byte)) begin
            if (prog_r == 2'd2) begin
              prog_nxt  = 2'd0;
              phase_nxt = PH_AFTER_KW;
            end else begin
              prog_nxt = prog_r + 2'd1;
            end
          end else begin
            prog_nxt = (in_data == CH_U) ? 2'd1 : 2'd0;
          end
        end
        PH_AFTER_KW: begin
          if (!ws) begin
            if (in_data == CH_LPAREN) begin
              phase_nxt = PH_AFTER_PAREN;
            end else begin
              phase_nxt = PH_SPAN;
              qp_nxt    = 1'b0;
              pp_nxt    = '0;
              if (in_data == CH_DQUOTE) begin
                kind_nxt  = TK_DQ;
                start_nxt = pos_inc;
              end else if (in_data == CH_SQUOTE) begin
                kind_nxt  = TK_SQ;
                start_nxt = pos_inc;
              end else begin
                kind_nxt  = TK_SEMI;
                start_nxt = pos_r;
              end
            end
          end
        end
        PH_AFTER_PAREN: begin
          if (!ws) begin
            phase_nxt = PH_SPAN;
            qp_nxt    = 1'b0;
            pp_nxt    = '0;
            if (in_data == CH_DQUOTE) begin
              kind_nxt  = TK_DQ_PAREN;
              start_nxt = pos_inc;
            end else if (in_data == CH_SQUOTE) begin
              kind_nxt  = TK_SQ_PAREN;
              start_nxt = pos_inc;
            end else begin
              kind_nxt  = TK_PAREN;
              start_nxt = pos_r;
            end
          end
        end
        PH_SPAN: begin
          // Track a closing quote that may precede the paren
          if ((kind_r == TK_DQ_PAREN) || (kind_r == TK_SQ_PAREN)) begin
            if (in_data == ((kind_r == TK_DQ_PAREN) ? CH_DQUOTE : CH_SQUOTE)) begin
              qp_nxt = 1'b1;
              pp_nxt = pos_r;
            end else begin
              qp_nxt = 1'b0;
            end
          end
        end
        default: begin
          phase_nxt = PH_SEEK;
          prog_nxt  = 2'd0;
        end
      endcase
      // Terminator closes the span and resumes the keyword search
      if (hit) begin
        phase_nxt = PH_SEEK;
        prog_nxt  = 2'd0;
        kind_nxt  = TK_NONE;
        qp_nxt    = 1'b0;
        pp_nxt    = '0;
      end
      pos_nxt = pos_inc;
      // End of buffer drops everything
      if (in_last) begin
        phase_nxt = PH_SEEK;
        prog_nxt  = 2'd0;
        kind_nxt  = TK_NONE;
        qp_nxt    = 1'b0;
        pp_nxt    = '0;
        start_nxt = '0;
        pos_nxt   = '0;
      end
    end
  end

  // Scanner state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEEK;
      prog_r  <= 2'd0;
      kind_r  <= TK_NONE;
      qp_r    <= 1'b0;
      pp_r    <= '0;
      start_r <= '0;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      prog_r  <= prog_nxt;
      kind_r  <= kind_nxt;
      qp_r    <= qp_nxt;
      pp_r    <= pp_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
    end
  end

`ifndef SYNTHESIS
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_last) |=> (phase_r == PH_SEEK) && (pos_r == '0) && (prog_r == 2'd0))
    else $error("scanner not back at start after end of buffer");

  a_quote_only_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    qp_r |-> (phase_r == PH_SPAN) &&
             ((kind_r == TK_DQ_PAREN) || (kind_r == TK_SQ_PAREN)))
    else $error("pending quote outside a quoted paren span");
`endif

endmodule

`default_nettype wire

// ===== hdl/cue_queue.sv =====
// Short result queue between scanner front end and output stage.
// Depends on cue_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cue_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cue_pkg::push_t push_i,
  output logic               full,
  output logic               q_valid,
  output cue_pkg::res_t      q_data,
  input  wire logic          pop
);
  import cue_pkg::*;

  res_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data  = slot_r[rd_r];
  assign do_pop  = pop && q_valid;

  // Advance pointers and fill level
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push_i.push) begin
      wr_nxt = (wr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + QPTR_W'(1);
    end
    case ({push_i.push, do_pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the pushed record
  always_ff @(posedge clk) begin
    if (push_i.push) begin
      slot_r[wr_r] <= push_i.res;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i.push && full))
    else $error("push into a full result queue");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue level out of range");

  a_level_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push_i.push && !do_pop) |=> (cnt_r == $past(cnt_r) + QCNT_W'(1)))
    else $error("result queue level did not rise on push");
`endif

endmodule

`default_nettype wire

// ===== hdl/cue_drain.sv =====
// Back end: moves queued results into the output register and presents them.
// Depends on cue_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cue_drain (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire cue_pkg::res_t q_data,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output cue_pkg::res_t      out_data
);
  import cue_pkg::*;

  logic valid_r, valid_nxt;
  res_t data_r;

  // Take the next record when the output register is free or being emptied
  assign pop       = q_valid && (!valid_r || out_ready);
  assign valid_nxt = pop || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= q_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

// ===== hdl/css_url_extractor_unit.sv =====
// Top level of the stylesheet URL span extractor: scanner, result queue, output stage.
// Depends on cue_pkg, cue_scan, cue_queue and cue_drain.
//
//  channel | direction | tdata                         | tlast        | tuser
//  in_     | slave     | [7:0] byte_value              | last_byte    | -
//  out_    | master    | [15:0] span_start,            | buffer_done  | [0] span_found
//          |           | [31:16] span_length           |              |
//
// One byte is taken every cycle while in_tready is high; a result passes through a queue
// entry and then the output register before it is presented on out_.
// A two-entry queue and the output register sit between scanner and result port, so
// in_tready falls only when both queue entries hold results that the sink has not taken.
// Reset is synchronous and active low; the scanner restarts at offset zero and after
// the final byte of each buffer.
`timescale 1ns / 1ps
`default_nettype none

module css_url_extractor_unit #(
  parameter int OFFSET_BITS = cue_pkg::OFFSET_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_value
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [15:0] span_start, [31:16] span_length
  output logic             out_tlast,  // buffer_done
  output logic             out_tuser   // [0] span_found
);
  import cue_pkg::*;

  push_t push;
  logic  q_full;
  logic  q_valid;
  res_t  q_data;
  logic  q_pop;
  res_t  out_res;

  cue_scan #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .q_full   (q_full),
    .push_o   (push)
  );

  cue_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .full    (q_full),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (q_pop)
  );

  cue_drain u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  // Pack the result transaction
  assign out_tdata = {out_res.length, out_res.start};
  assign out_tlast = out_res.done;
  assign out_tuser = out_res.found;

endmodule

`default_nettype wire
